// ----- rtl/cmt_pkg.sv -----
// Package for the compare-match timer: codes, register offsets and shared types.
`timescale 1ns / 1ps

package cmt_pkg;

    // Channel count limits; the output masks are always CMT_MAX_CH wide
    localparam int CMT_MAX_CH = 3;
    localparam int CMT_NUM_CH = 3;

    // Register window
    localparam int CMT_NUM_REGS  = 32;
    localparam int CMT_OFF_W     = 5;
    localparam int CMT_CHAN_BASE = 8;
    localparam int CMT_CHAN_STEP = 8;

    // Word kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    // Fixed offsets
    localparam logic [CMT_OFF_W-1:0] OFF_START  = 5'd0;
    localparam logic [CMT_OFF_W-1:0] OFF_STAT_A = 5'd4;
    localparam logic [CMT_OFF_W-1:0] OFF_STAT_B = 5'd5;
    localparam logic [CMT_OFF_W-1:0] OFF_STAT_O = 5'd6;

    // Offsets inside a channel's block of eight bytes
    localparam int CH_CTL    = 0;
    localparam int CH_ENA    = 1;
    localparam int CH_CNT_H  = 2;
    localparam int CH_CNT_L  = 3;
    localparam int CH_CMPA_H = 4;
    localparam int CH_CMPA_L = 5;
    localparam int CH_CMPB_H = 6;
    localparam int CH_CMPB_L = 7;

    // Clear-on-match selection, control bits 6:5
    localparam logic [1:0] CLR_ON_A = 2'd1;
    localparam logic [1:0] CLR_ON_B = 2'd2;

    // Start register reads back with its upper bits set
    localparam logic [7:0] START_RD_SET = 8'hF8;

    // Interrupt enables sit from bit 4 of each status byte
    localparam int IEN_LSB = 4;

    // Stream word widths
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;

    typedef struct packed {
        logic [1:0]           kind;
        logic [CMT_OFF_W-1:0] offset;
        logic [7:0]           wdata;
    } t_item;

    typedef struct packed {
        logic [7:0]            rdata;
        logic [CMT_MAX_CH-1:0] irq_a;
        logic [CMT_MAX_CH-1:0] irq_b;
        logic [CMT_MAX_CH-1:0] irq_o;
    } t_result;

    // Outcome of one tick on one channel
    typedef struct packed {
        logic        evt;
        logic [2:0]  phase;
        logic [15:0] cnt;
        logic        running;
        logic        hit_a;
        logic        hit_b;
        logic        ovf;
    } t_ch_step;

endpackage

// ----- rtl/cmt_channel.sv -----
// Per-channel tick logic: prescaler step, count increment and the compare chain.
`timescale 1ns / 1ps

module cmt_channel
    import cmt_pkg::*;
(
    input  logic [7:0]  i_ctl,
    input  logic [7:0]  i_ena,
    input  logic [15:0] i_cnt,
    input  logic [15:0] i_cmpa,
    input  logic [15:0] i_cmpb,
    input  logic [2:0]  i_phase,
    output t_ch_step    o_step
);

    logic [3:0]  w_next;
    logic [3:0]  w_scale;
    logic [15:0] w_cnt1;
    logic [15:0] w_cnt_a;
    logic [1:0]  w_mode;
    logic        w_clr_a;
    logic        w_clr_b;
    logic        w_run_a;

    // Prescaler: divide by 1, 2, 4 or 8
    assign w_next  = {1'b0, i_phase} + 4'd1;
    assign w_scale = 4'd1 << i_ctl[1:0];
    assign o_step.evt   = (w_next >= w_scale);
    assign o_step.phase = o_step.evt ? 3'd0 : w_next[2:0];

    assign w_mode  = i_ctl[6:5];
    assign w_clr_a = (w_mode == CLR_ON_A);
    assign w_clr_b = (w_mode == CLR_ON_B);
    assign w_cnt1  = i_cnt + 16'd1;

    // Compare A first, then B sees the count as A left it
    assign o_step.hit_a = (|i_ena[1:0]) && (w_cnt1 == i_cmpa);
    assign w_cnt_a      = (o_step.hit_a && w_clr_a) ? 16'd0 : w_cnt1;
    assign w_run_a      = o_step.hit_a ? w_clr_a : 1'b1;

    assign o_step.hit_b   = (|i_ena[5:4]) && (w_cnt_a == i_cmpb);
    assign o_step.cnt     = (o_step.hit_b && w_clr_b) ? 16'd0 : w_cnt_a;
    assign o_step.running = o_step.hit_b ? w_clr_b : w_run_a;

    // Overflow only when both compares are off
    assign o_step.ovf = (i_ena[1:0] == 2'd0) && (i_ena[5:4] == 2'd0)
                        && (o_step.cnt == 16'd0);

endmodule

// ----- rtl/cmt_core.sv -----
// Timer state: register window, run bits and prescalers, with the per-word update.
`timescale 1ns / 1ps

module cmt_core
    import cmt_pkg::*;
#(
    parameter int NUM_CHANNELS = CMT_NUM_CH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  t_item   i_item,
    output t_result o_res
);

    logic [7:0]              r_regs [CMT_NUM_REGS];
    logic [7:0]              n_regs [CMT_NUM_REGS];
    logic [NUM_CHANNELS-1:0] r_run;
    logic [NUM_CHANNELS-1:0] n_run;
    logic [2:0]              r_phase [NUM_CHANNELS];
    logic [2:0]              n_phase [NUM_CHANNELS];

    logic [CMT_MAX_CH-1:0]   w_hit_a;
    logic [CMT_MAX_CH-1:0]   w_hit_b;
    logic [CMT_MAX_CH-1:0]   w_hit_o;
    logic [CMT_MAX_CH-1:0]   w_cnt_we;
    logic [15:0]             w_cnt [CMT_MAX_CH];

    logic                    w_is_tick;
    logic                    w_wr_start;

    assign w_is_tick  = (i_item.kind == KIND_TICK);
    assign w_wr_start = (i_item.kind == KIND_WRITE) && (i_item.offset == OFF_START);

    // Per-channel tick logic and run / prescaler next state
    for (genvar c = 0; c < CMT_MAX_CH; c++) begin : g_ch
        if (c < NUM_CHANNELS) begin : g_on
            localparam int Base = CMT_CHAN_BASE + CMT_CHAN_STEP * c;
            t_ch_step w_step;
            logic     w_act;
            logic     w_rise;
            logic     w_fall;

            cmt_channel u_channel (
                .i_ctl   (r_regs[Base + CH_CTL]),
                .i_ena   (r_regs[Base + CH_ENA]),
                .i_cnt   ({r_regs[Base + CH_CNT_H], r_regs[Base + CH_CNT_L]}),
                .i_cmpa  ({r_regs[Base + CH_CMPA_H], r_regs[Base + CH_CMPA_L]}),
                .i_cmpb  ({r_regs[Base + CH_CMPB_H], r_regs[Base + CH_CMPB_L]}),
                .i_phase (r_phase[c]),
                .o_step  (w_step)
            );

            // Count event on this tick
            assign w_act       = w_is_tick && r_run[c] && w_step.evt;
            assign w_hit_a[c]  = w_act && w_step.hit_a;
            assign w_hit_b[c]  = w_act && w_step.hit_b;
            assign w_hit_o[c]  = w_act && w_step.ovf;
            assign w_cnt_we[c] = w_act;
            assign w_cnt[c]    = w_step.cnt;

            // Start bit edges
            assign w_rise = w_wr_start && i_item.wdata[c] && !r_regs[OFF_START][c];
            assign w_fall = w_wr_start && !i_item.wdata[c] && r_regs[OFF_START][c];

            assign n_run[c] = w_rise ? 1'b1 :
                              w_fall ? 1'b0 :
                              w_act  ? w_step.running : r_run[c];
            assign n_phase[c] = w_rise ? 3'd0 :
                                (w_is_tick && r_run[c]) ? w_step.phase : r_phase[c];
        end else begin : g_off
            assign w_hit_a[c]  = 1'b0;
            assign w_hit_b[c]  = 1'b0;
            assign w_hit_o[c]  = 1'b0;
            assign w_cnt_we[c] = 1'b0;
            assign w_cnt[c]    = 16'd0;
        end
    end

    // Register window update and result
    always_comb begin
        n_regs = r_regs;
        o_res  = '0;
        case (i_item.kind)
            KIND_TICK: begin
                for (int c = 0; c < CMT_MAX_CH; c++) begin
                    if (w_cnt_we[c]) begin
                        n_regs[CMT_OFF_W'(CMT_CHAN_BASE + CMT_CHAN_STEP * c + CH_CNT_H)] =
                            w_cnt[c][15:8];
                        n_regs[CMT_OFF_W'(CMT_CHAN_BASE + CMT_CHAN_STEP * c + CH_CNT_L)] =
                            w_cnt[c][7:0];
                    end
                end
                n_regs[OFF_STAT_A][CMT_MAX_CH-1:0] = r_regs[OFF_STAT_A][CMT_MAX_CH-1:0] | w_hit_a;
                n_regs[OFF_STAT_B][CMT_MAX_CH-1:0] = r_regs[OFF_STAT_B][CMT_MAX_CH-1:0] | w_hit_b;
                n_regs[OFF_STAT_O][CMT_MAX_CH-1:0] = r_regs[OFF_STAT_O][CMT_MAX_CH-1:0] | w_hit_o;
                o_res.irq_a = w_hit_a & r_regs[OFF_STAT_A][IEN_LSB +: CMT_MAX_CH];
                o_res.irq_b = w_hit_b & r_regs[OFF_STAT_B][IEN_LSB +: CMT_MAX_CH];
                o_res.irq_o = w_hit_o & r_regs[OFF_STAT_O][IEN_LSB +: CMT_MAX_CH];
            end
            KIND_READ: begin
                if (i_item.offset == OFF_START) begin
                    o_res.rdata = r_regs[OFF_START] | START_RD_SET;
                end else begin
                    o_res.rdata = r_regs[i_item.offset];
                end
            end
            KIND_WRITE: begin
                n_regs[i_item.offset] = i_item.wdata;
            end
            default: begin
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CMT_NUM_REGS; i++) begin
                r_regs[i] <= 8'd0;
            end
            r_run <= '0;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_phase[c] <= 3'd0;
            end
        end else if (i_en) begin
            r_regs <= n_regs;
            r_run  <= n_run;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_phase[c] <= n_phase[c];
            end
        end
    end

    // A rising start bit on channel 0 leaves it running
    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && w_wr_start && i_item.wdata[0] && !r_regs[OFF_START][0] |=> r_run[0])
        else $error("channel 0 not running after start");

    // Status bytes only move when a word is processed
    a_stat_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> (r_regs[OFF_STAT_A] == $past(r_regs[OFF_STAT_A])) &&
                  (r_regs[OFF_STAT_B] == $past(r_regs[OFF_STAT_B])))
        else $error("status byte changed without a word");

    // Interrupts come from ticks only
    a_irq_tick_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_is_tick |-> (o_res.irq_a == '0) && (o_res.irq_b == '0) && (o_res.irq_o == '0))
        else $error("interrupt raised by a register access");

    // A stopped channel's prescaler does not advance on a tick
    a_phase_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && w_is_tick && !r_run[0] |=> r_phase[0] == $past(r_phase[0]))
        else $error("prescaler moved on a stopped channel");

endmodule

// ----- rtl/compare_match_timer_unit.sv -----
// Top level of the compare-match timer: stream ports, input and result registers.
//
// Usage:
//   The slave channel carries one word per tick, register read or register
//   write: s_tuser holds the kind, s_tdata the byte offset and the write byte.
//   Every accepted word gives exactly one result word on the master channel:
//   the read byte (zero for ticks and writes) and three per-channel masks of
//   interrupts raised by that word (zero for reads and writes).
//   Path: an accepted word is held in the input register, processed by the
//   core into the result register when that is free, and offered on the
//   master channel from there. Throughput is one word per cycle while the
//   receiver takes results; every word is finished in one pass through the
//   channel compare logic between the input register and the result register.
//   Reset (i_rst_n low, synchronous) clears the whole register window, stops
//   all channels and zeroes the prescalers; both stream sides come up empty.
//   When the receiver stalls, the result register holds its word and the
//   input register takes one more word; s_tready then drops until the
//   result is taken.
`timescale 1ns / 1ps

module compare_match_timer_unit
    import cmt_pkg::*;
#(
    parameter int NUM_CHANNELS = CMT_NUM_CH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [4:0] reg_offset, [12:5] write_data
    input  logic [S_TUSER_W-1:0] s_tuser,   // [1:0] kind
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [7:0] read_data, [10:8] irq_match_a,
                                            // [13:11] irq_match_b, [16:14] irq_overflow
);

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_out;
    t_result w_res;
    logic    w_adv;

    // Process the held word when the result register is free
    assign w_adv    = r_in_valid && (!r_out_valid || m_tready);
    assign s_tready = !r_in_valid || w_adv;

    cmt_core #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_item  (r_item),
        .o_res   (w_res)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_item.kind   <= s_tuser[1:0];
            r_item.offset <= s_tdata[CMT_OFF_W-1:0];
            r_item.wdata  <= s_tdata[CMT_OFF_W +: 8];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {7'd0, r_out.irq_o, r_out.irq_b, r_out.irq_a, r_out.rdata};

endmodule

// ----- bench/compare_match_timer_unit_tb.sv -----
// Self-checking bench for the compare-match timer: directed cases, random timer runs, flow control.
`timescale 1ns / 1ps

module compare_match_timer_unit_tb;
    import cmt_pkg::*;

    // Kind code the block leaves undefined; it must answer with an all-zero word
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int DRAIN_SLACK     = 4;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int MAX_PRINTED     = 40;

    logic                 i_clk;
    logic                 i_rst_n  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // [4:0] reg_offset, [12:5] write_data
    logic [S_TUSER_W-1:0] s_tuser  = '0;   // [1:0] kind
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // [7:0] read_data, [10:8] irq_match_a,
                                           // [13:11] irq_match_b, [16:14] irq_overflow

    compare_match_timer_unit i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Mirror of the timer state
    logic [7:0] tmr_regs [CMT_NUM_REGS];
    logic [7:0] tmr_start;
    logic       ch_running [CMT_MAX_CH];
    logic [2:0] ch_phase [CMT_MAX_CH];

    t_result     timer_results_due [$];
    int unsigned words_sent    = 0;
    int unsigned n_errors      = 0;
    int unsigned tx_idle_pct   = 0;
    int unsigned rx_stall_pct  = 0;
    int unsigned rx_hold_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [CMT_OFF_W-1:0] ch_reg(input int unsigned c, input int field);
        return CMT_OFF_W'(CMT_CHAN_BASE + CMT_CHAN_STEP * c + field);
    endfunction

    // One count of channel c: compare, clear or stop, flags and interrupts
    function automatic void count_once(input int unsigned c, inout logic [2:0] ia,
                                       inout logic [2:0] ib, inout logic [2:0] io);
        logic [7:0]  ctl;
        logic [7:0]  ena;
        logic [15:0] cnt;
        logic [15:0] cmpa;
        logic [15:0] cmpb;
        ctl  = tmr_regs[ch_reg(c, CH_CTL)];
        ena  = tmr_regs[ch_reg(c, CH_ENA)];
        cnt  = {tmr_regs[ch_reg(c, CH_CNT_H)], tmr_regs[ch_reg(c, CH_CNT_L)]} + 16'd1;
        cmpa = {tmr_regs[ch_reg(c, CH_CMPA_H)], tmr_regs[ch_reg(c, CH_CMPA_L)]};
        cmpb = {tmr_regs[ch_reg(c, CH_CMPB_H)], tmr_regs[ch_reg(c, CH_CMPB_L)]};
        if (ena[1:0] != 2'd0 && cnt == cmpa) begin
            if (ctl[6:5] == CLR_ON_A) begin
                cnt = '0;
                ch_running[c] = 1'b1;
                ch_phase[c] = '0;
            end else begin
                ch_running[c] = 1'b0;
            end
            tmr_regs[OFF_STAT_A][c] = 1'b1;
            if (tmr_regs[OFF_STAT_A][IEN_LSB + c]) ia[c] = 1'b1;
        end
        // B sees the count as A left it
        if (ena[5:4] != 2'd0 && cnt == cmpb) begin
            if (ctl[6:5] == CLR_ON_B) begin
                cnt = '0;
                ch_running[c] = 1'b1;
                ch_phase[c] = '0;
            end else begin
                ch_running[c] = 1'b0;
            end
            tmr_regs[OFF_STAT_B][c] = 1'b1;
            if (tmr_regs[OFF_STAT_B][IEN_LSB + c]) ib[c] = 1'b1;
        end
        if (ena[1:0] == 2'd0 && ena[5:4] == 2'd0 && cnt == 16'd0) begin
            tmr_regs[OFF_STAT_O][c] = 1'b1;
            if (tmr_regs[OFF_STAT_O][IEN_LSB + c]) io[c] = 1'b1;
        end
        tmr_regs[ch_reg(c, CH_CNT_H)] = cnt[15:8];
        tmr_regs[ch_reg(c, CH_CNT_L)] = cnt[7:0];
    endfunction

    // Expected result word for one accepted input word; updates the mirror
    function automatic t_result timer_step(input logic [1:0] kind,
                                           input logic [CMT_OFF_W-1:0] off,
                                           input logic [7:0] data);
        t_result     res;
        logic [2:0]  ia;
        logic [2:0]  ib;
        logic [2:0]  io;
        int unsigned nxt;
        res = '0;
        ia = '0;
        ib = '0;
        io = '0;
        case (kind)
            KIND_TICK: begin
                for (int unsigned c = 0; c < CMT_NUM_CH; c++) begin
                    if (ch_running[c]) begin
                        nxt = ch_phase[c] + 1;
                        if (nxt >= (1 << tmr_regs[ch_reg(c, CH_CTL)][1:0])) begin
                            ch_phase[c] = '0;
                            count_once(c, ia, ib, io);
                        end else begin
                            ch_phase[c] = 3'(nxt);
                        end
                    end
                end
            end
            KIND_READ: begin
                res.rdata = (off == OFF_START) ? (tmr_start | START_RD_SET) : tmr_regs[off];
            end
            KIND_WRITE: begin
                tmr_regs[off] = data;
                if (off == OFF_START) begin
                    for (int unsigned c = 0; c < CMT_NUM_CH; c++) begin
                        if (data[c] && !tmr_start[c]) begin
                            ch_running[c] = 1'b1;
                            ch_phase[c] = '0;
                        end else if (!data[c] && tmr_start[c]) begin
                            ch_running[c] = 1'b0;
                        end
                    end
                    tmr_start = data;
                end
            end
            default: ;
        endcase
        res.irq_a = ia;
        res.irq_b = ib;
        res.irq_o = io;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        n_errors++;
        if (n_errors <= MAX_PRINTED)
            $display("%0t ns: %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    endtask

    task automatic check_result(input logic [M_TDATA_W-1:0] word);
        t_result want;
        if (timer_results_due.size() == 0) begin
            report_mismatch("result word with none outstanding", 0, word);
            return;
        end
        want = timer_results_due.pop_front();
        if (word[7:0] !== want.rdata)   report_mismatch("read_data", want.rdata, word[7:0]);
        if (word[10:8] !== want.irq_a)  report_mismatch("irq_match_a", want.irq_a, word[10:8]);
        if (word[13:11] !== want.irq_b) report_mismatch("irq_match_b", want.irq_b, word[13:11]);
        if (word[16:14] !== want.irq_o) report_mismatch("irq_overflow", want.irq_o, word[16:14]);
        if (word[23:17] !== 7'd0)       report_mismatch("tdata padding", 0, word[23:17]);
    endtask

    // Receiver: check each accepted word, then choose next tready
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) check_result(m_tdata);
        if (rx_hold_cycles > 0) begin
            rx_hold_cycles--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99, 0) >= rx_stall_pct);
        end
    end

    // Watchdog on cycles with no word moving on either side
    int unsigned quiet_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("compare_match_timer_unit: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one word, wait for its handshake, queue its expected result
    task automatic send_word(input logic [1:0] kind, input logic [CMT_OFF_W-1:0] off,
                             input logic [7:0] data);
        while ($urandom_range(99, 0) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {3'b000, data, off};
        do @(posedge i_clk); while (!s_tready);
        timer_results_due.push_back(timer_step(kind, off, data));
        if (kind != KIND_UNUSED) words_sent++;
    endtask

    task automatic write_reg(input logic [CMT_OFF_W-1:0] off, input logic [7:0] data);
        send_word(KIND_WRITE, off, data);
    endtask

    task automatic read_reg(input logic [CMT_OFF_W-1:0] off);
        send_word(KIND_READ, off, 8'h00);
    endtask

    task automatic tick(input int unsigned n);
        repeat (n) send_word(KIND_TICK, 5'($urandom), 8'($urandom));
    endtask

    // Sender pauses until every result is back
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (timer_results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    task automatic test_reset_readback();
        read_reg(OFF_START);
        read_reg(OFF_STAT_A);
    endtask

    // Channel 0 clears on A at scale 1; B matches the cleared count and stops it
    task automatic test_clear_on_a_then_b();
        write_reg(OFF_STAT_A, 8'h10);
        write_reg(OFF_STAT_B, 8'h70);
        write_reg(ch_reg(0, CH_CTL), {1'b0, CLR_ON_A, 5'b00000});
        write_reg(ch_reg(0, CH_ENA), 8'h33);
        write_reg(ch_reg(0, CH_CMPA_L), 8'h02);
        write_reg(OFF_START, 8'h01);
        tick(3);
    endtask

    // Channel 1 wraps with no compare enabled; scale cut mid-run; start falling
    task automatic test_overflow_and_prescale();
        write_reg(ch_reg(1, CH_CNT_H), 8'hFF);
        write_reg(ch_reg(1, CH_CNT_L), 8'hFF);
        write_reg(ch_reg(1, CH_CTL), 8'h03);
        write_reg(OFF_STAT_O, 8'h20);
        write_reg(OFF_START, 8'h03);
        tick(2);
        write_reg(ch_reg(1, CH_CTL), 8'h00);
        tick(1);
        write_reg(OFF_START, 8'h01);
        tick(1);
    endtask

    // Top offset, full bytes, undefined kind, start bits of absent channels
    task automatic test_field_extremes();
        write_reg(5'd31, 8'hFF);
        read_reg(5'd31);
        send_word(KIND_UNUSED, 5'd31, 8'hFF);
        write_reg(OFF_START, 8'hF8);
        read_reg(OFF_START);
    endtask

    // Random runs: set up a channel, start it, tick with scattered noise words
    task automatic run_timer_bursts(input int unsigned n_words);
        int unsigned stop_at;
        int unsigned c;
        int unsigned pick;
        logic [7:0]  ena_val;
        logic [7:0]  start_val;
        logic [15:0] cnt_init;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at) begin
            c = $urandom_range(CMT_NUM_CH - 1, 0);
            write_reg(ch_reg(c, CH_CTL), 8'($urandom));
            case ($urandom_range(4, 0))
                0:       ena_val = 8'h03;
                1:       ena_val = 8'h30;
                2:       ena_val = 8'h33;
                3:       ena_val = 8'h00;
                default: ena_val = 8'($urandom);
            endcase
            write_reg(ch_reg(c, CH_ENA), ena_val);
            write_reg(ch_reg(c, CH_CMPA_H), ($urandom_range(7, 0) == 0) ? 8'($urandom) : 8'h00);
            write_reg(ch_reg(c, CH_CMPA_L), 8'($urandom_range(24, 0)));
            write_reg(ch_reg(c, CH_CMPB_H), ($urandom_range(7, 0) == 0) ? 8'($urandom) : 8'h00);
            write_reg(ch_reg(c, CH_CMPB_L), 8'($urandom_range(24, 0)));
            cnt_init = ($urandom_range(3, 0) == 0) ? 16'hFFFF - 16'($urandom_range(8, 0))
                                                    : 16'($urandom_range(4, 0));
            write_reg(ch_reg(c, CH_CNT_H), cnt_init[15:8]);
            write_reg(ch_reg(c, CH_CNT_L), cnt_init[7:0]);
            if ($urandom_range(1, 0)) write_reg(OFF_STAT_A, 8'($urandom));
            if ($urandom_range(1, 0)) write_reg(OFF_STAT_B, 8'($urandom));
            if ($urandom_range(1, 0)) write_reg(OFF_STAT_O, 8'($urandom));
            // force a clean rising edge on this channel's start bit
            start_val = {5'($urandom), tmr_start[2:0]};
            start_val[c] = 1'b0;
            write_reg(OFF_START, start_val);
            start_val[c] = 1'b1;
            write_reg(OFF_START, start_val);
            repeat ($urandom_range(80, 20)) begin
                pick = $urandom_range(99, 0);
                if (pick < 8)
                    read_reg(5'($urandom));
                else if (pick < 11)
                    write_reg(5'($urandom), 8'($urandom));
                else if (pick < 13)
                    send_word(KIND_UNUSED, 5'($urandom), 8'($urandom));
                else
                    tick(1);
            end
        end
    endtask

    // Receiver holds off while ticks keep coming, so the block fills and stalls
    task automatic test_output_backpressure();
        write_reg(OFF_START, 8'h00);
        write_reg(OFF_START, 8'h07);
        rx_hold_cycles = HOLD_OFF_CYCLES;
        tick(24);
        wait_results_drained();
    endtask

    task automatic run_idle_phase(input int unsigned tx_pct, input int unsigned rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        run_timer_bursts(290);
        wait_results_drained();
    endtask

    initial begin
        for (int i = 0; i < CMT_NUM_REGS; i++) tmr_regs[i] = '0;
        for (int i = 0; i < CMT_MAX_CH; i++) begin
            ch_running[i] = 1'b0;
            ch_phase[i] = '0;
        end
        tmr_start = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_readback();
        test_clear_on_a_then_b();
        test_overflow_and_prescale();
        test_field_extremes();
        wait_results_drained();

        run_idle_phase(0, 0);
        run_idle_phase(66, 0);
        run_idle_phase(0, 66);
        run_idle_phase(30, 30);

        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        test_output_backpressure();

        if (n_errors == 0 && timer_results_due.size() == 0)
            $display("compare_match_timer_unit: match");
        else
            $display("compare_match_timer_unit: mismatch");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/cmt_pkg.sv
rtl/cmt_channel.sv
rtl/cmt_core.sv
rtl/compare_match_timer_unit.sv
bench/compare_match_timer_unit_tb.sv
